// ===== sv/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants for the JPEG DC MCU scatter block
// Field widths, register indexes, the sequencer control word and its program.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int MAX_DUS_SIDE_DEF = 8192;
  localparam int MAX_SAMPLING_DEF = 4;

  localparam int DC_W       = 12;
  localparam int IDX_W      = 26;
  localparam int PIX_W      = 8;
  localparam int SF_W       = 3;
  localparam int DUS_W      = 14;
  localparam int PRED_W     = 16;
  localparam int WI_W       = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int PIX_BIAS = 128;
  localparam int PIX_MAX  = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMP_H     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMP_V     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MCU_H      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MCU_V      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUS_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUS_DOWN   = 3'd5;

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SIZE     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PIX      = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE     = 3'd5;
  localparam logic [STEP_W-1:0] STEP_OVF      = 3'd6;
  localparam logic [STEP_W-1:0] STEP_OVF_DONE = 3'd7;

  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEXT   = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] COND_IDLE   = 3'd2;
  localparam logic [COND_W-1:0] COND_OVER   = 3'd3;
  localparam logic [COND_W-1:0] COND_LOOP   = 3'd4;
  localparam logic [COND_W-1:0] COND_STALL  = 3'd5;

  typedef struct packed {
    logic in_ready;
    logic ld_size;
    logic chk;
    logic ld_pix;
    logic emit;
    logic emit_ovf;
  } ctrl_t;

  typedef struct packed {
    logic over;
    logic blocked;
    logic more;
  } status_t;

  typedef struct packed {
    ctrl_t               ctrl;
    logic [COND_W-1:0]   cond;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.ctrl.in_ready = 1'b1;
        w.cond          = COND_IDLE;
        w.target        = STEP_IDLE;
      end
      STEP_SIZE: begin
        w.ctrl.ld_size = 1'b1;
        w.cond         = COND_NEXT;
      end
      STEP_CHECK: begin
        w.ctrl.chk = 1'b1;
        w.cond     = COND_OVER;
        w.target   = STEP_OVF;
      end
      STEP_PIX: begin
        w.ctrl.ld_pix = 1'b1;
        w.cond        = COND_NEXT;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_LOOP;
        w.target    = STEP_EMIT;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_OVF: begin
        w.ctrl.emit_ovf = 1'b1;
        w.cond          = COND_STALL;
        w.target        = STEP_OVF;
      end
      STEP_OVF_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dcs_if.sv =====
// ----------------------------------------------------------------------------
// dcs_if: request channels of the JPEG DC MCU scatter block
// One channel carries DC differences in, the other carries pixel writes out.
// ----------------------------------------------------------------------------
interface dcs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dcs_pkg::DC_W-1:0]   dc_diff;

  modport source(output valid, output dc_diff, input ready);
  modport sink(input valid, input dc_diff, output ready);
endinterface

interface dcs_out_if;
  logic                              valid;
  logic                              ready;
  logic [dcs_pkg::IDX_W-1:0]         entry_index;
  logic [dcs_pkg::PIX_W-1:0]         pixel_value;
  logic                              last_write;
  logic                              grid_full;
  logic                              overflow;

  modport source(output valid, output entry_index, output pixel_value, output last_write,
                 output grid_full, output overflow, input ready);
  modport sink(input valid, input entry_index, input pixel_value, input last_write,
               input grid_full, input overflow, output ready);
endinterface

// ===== sv/dcs_seq.sv =====
// ----------------------------------------------------------------------------
// dcs_seq: microcode sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module dcs_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dcs_pkg::status_t status,
  output dcs_pkg::ctrl_t   ctrl
);
  import dcs_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uword;
  logic              take;

  assign uword = ucode_rom(step);
  assign ctrl  = uword.ctrl;

  always_comb begin
    case (uword.cond)
      COND_NEXT:   take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_IDLE:   take = !in_valid;
      COND_OVER:   take = status.over;
      COND_LOOP:   take = status.blocked || status.more;
      COND_STALL:  take = status.blocked;
      default:     take = 1'b0;
    endcase
    step_next = take ? uword.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/dcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dcs_datapath: predictor, walk counters and output register
// Executes the control word of the sequencer, one pixel write per emit step unless the output stalls.
// ----------------------------------------------------------------------------
module dcs_datapath #(
  parameter int MAX_DUS_SIDE = dcs_pkg::MAX_DUS_SIDE_DEF,
  parameter int MAX_SAMPLING = dcs_pkg::MAX_SAMPLING_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dcs_pkg::ctrl_t                      ctrl,
  output dcs_pkg::status_t                    status,
  input  logic                                in_accept,
  input  logic signed [dcs_pkg::DC_W-1:0]     dc_diff,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dcs_pkg::IDX_W-1:0]           entry_index,
  output logic [dcs_pkg::PIX_W-1:0]           pixel_value,
  output logic                                last_write,
  output logic                                grid_full,
  output logic                                overflow
);
  import dcs_pkg::*;

  localparam int BURST = MAX_SAMPLING * MAX_SAMPLING;
  localparam int CNT_W = $clog2(BURST + 1);
  localparam logic [DUS_W-1:0] SIDE_MAX = DUS_W'(MAX_DUS_SIDE);

  logic [SF_W-1:0]            samp_h, samp_v, mcu_h, mcu_v;
  logic [DUS_W-1:0]           dus_across, dus_down;
  logic signed [DC_W-1:0]     dc_reg;
  logic [PRED_W-1:0]          predictor;
  logic [PIX_W-1:0]           pixel;
  logic [SF_W-1:0]            local_col, local_row;
  logic [DUS_W-1:0]           global_col, global_row;
  logic [WI_W-1:0]            write_index;
  logic [WI_W-1:0]            size, col_step, row_step;
  logic [CNT_W-1:0]           cnt;

  logic [DUS_W-1:0]           da, dd;
  logic [2*DUS_W-1:0]         prod_size;
  logic [SF_W+DUS_W-1:0]      prod_row;
  logic                       over;
  logic                       blocked, fire, ovf_fire;

  logic [SF_W-1:0]            lc1, lr1, local_col_next, local_row_next;
  logic [DUS_W-1:0]           gc1, gr1, global_col_next, global_row_next;
  logic [WI_W-1:0]            delta, write_index_next;
  logic                       full_next, more;

  logic signed [PRED_W-1:0]   pred_adj;
  logic signed [PRED_W-4:0]   quot;
  logic signed [PRED_W-3:0]   biased;
  logic [PIX_W-1:0]           pix_calc;

  assign da        = (dus_across > SIDE_MAX) ? SIDE_MAX : dus_across;
  assign dd        = (dus_down > SIDE_MAX) ? SIDE_MAX : dus_down;
  assign prod_size = da * dd;
  assign prod_row  = mcu_v * da;
  assign over      = write_index >= size;
  assign blocked   = out_valid && !out_ready;
  assign fire      = ctrl.emit && !blocked;
  assign ovf_fire  = ctrl.emit_ovf && !blocked;

  always_comb begin
    lc1             = local_col + 1'b1;
    lr1             = local_row + 1'b1;
    gc1             = global_col + 1'b1;
    gr1             = global_row + 1'b1;
    local_col_next  = lc1;
    local_row_next  = local_row;
    global_col_next = gc1;
    global_row_next = global_row;
    delta           = WI_W'(1);
    if (lc1 == mcu_h) begin
      local_col_next  = '0;
      local_row_next  = lr1;
      global_row_next = gr1;
      if (lr1 == mcu_v) begin
        local_row_next = '0;
        if (gc1 >= da) begin
          global_col_next = '0;
        end else begin
          global_row_next = gr1 - DUS_W'(mcu_v);
          delta           = row_step;
        end
      end else begin
        global_col_next = gc1 - DUS_W'(lc1);
        delta           = col_step;
      end
    end
    write_index_next = write_index + delta;
    full_next        = write_index_next >= size;
    more             = !full_next
                       && (local_col_next >= samp_h || local_row_next >= samp_v)
                       && (cnt != CNT_W'(BURST - 1));
  end

  always_comb begin
    pred_adj = $signed(predictor) + (predictor[PRED_W-1] ? PRED_W'(7) : PRED_W'(0));
    quot     = pred_adj[PRED_W-1:3];
    biased   = $signed({quot[PRED_W-4], quot}) + $signed((PRED_W-2)'(PIX_BIAS));
    if (biased < 0) begin
      pix_calc = '0;
    end else if (biased > $signed((PRED_W-2)'(PIX_MAX))) begin
      pix_calc = PIX_W'(PIX_MAX);
    end else begin
      pix_calc = biased[PIX_W-1:0];
    end
  end

  assign status.over    = over;
  assign status.blocked = blocked;
  assign status.more    = more;

  always_ff @(posedge clk) begin
    if (rst) begin
      samp_h      <= SF_W'(1);
      samp_v      <= SF_W'(1);
      mcu_h       <= SF_W'(1);
      mcu_v       <= SF_W'(1);
      dus_across  <= DUS_W'(1);
      dus_down    <= DUS_W'(1);
      predictor   <= '0;
      local_col   <= '0;
      local_row   <= '0;
      global_col  <= '0;
      global_row  <= '0;
      write_index <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMP_H:     samp_h     <= cfg_data[SF_W-1:0];
          CFG_SAMP_V:     samp_v     <= cfg_data[SF_W-1:0];
          CFG_MCU_H:      mcu_h      <= cfg_data[SF_W-1:0];
          CFG_MCU_V:      mcu_v      <= cfg_data[SF_W-1:0];
          CFG_DUS_ACROSS: dus_across <= cfg_data[DUS_W-1:0];
          CFG_DUS_DOWN:   dus_down   <= cfg_data[DUS_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.chk && !over) begin
        predictor <= predictor + PRED_W'(dc_reg);
      end
      if (ctrl.ld_pix) begin
        cnt <= '0;
      end
      if (fire) begin
        local_col   <= local_col_next;
        local_row   <= local_row_next;
        global_col  <= global_col_next;
        global_row  <= global_row_next;
        write_index <= write_index_next;
        cnt         <= cnt + 1'b1;
      end
      if (fire || ovf_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dc_reg <= dc_diff;
    end
    if (ctrl.ld_size) begin
      size     <= prod_size[WI_W-1:0];
      col_step <= WI_W'(da) - WI_W'(mcu_h) + WI_W'(1);
      row_step <= WI_W'(da) + WI_W'(1) - WI_W'(prod_row);
    end
    if (ctrl.ld_pix) begin
      pixel <= pix_calc;
    end
    if (fire) begin
      entry_index <= write_index[IDX_W-1:0];
      pixel_value <= pixel;
      last_write  <= !more;
      grid_full   <= full_next;
      overflow    <= 1'b0;
    end else if (ovf_fire) begin
      entry_index <= '0;
      pixel_value <= '0;
      last_write  <= 1'b1;
      grid_full   <= 1'b1;
      overflow    <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_ovf_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last_write && grid_full)
    else $error("overflow result without last_write and grid_full");

  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> {1'b0, entry_index} < size)
    else $error("pixel written outside the grid");

  a_full_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && grid_full |-> last_write)
    else $error("write burst continues past a full grid");

  a_burst_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(BURST))
    else $error("write burst longer than the sampling limit");
`endif

endmodule

// ===== sv/jpeg_dc_mcu_scatter_top.sv =====
// ----------------------------------------------------------------------------
// jpeg_dc_mcu_scatter_top: JPEG DC prediction and MCU-order pixel scatter
// Accumulates DC differences and writes each pixel over its MCU footprint.
// ----------------------------------------------------------------------------
// Sequence: after accept, the size, check and pixel steps run in order, then the
// emit step of the microcode loop registers the n writes of the request (1 to 16),
// one write per cycle while the output is not stalled; an overflow request
// emits one overflow result instead.
// Reset (synchronous, rst high): configuration registers return to 1, predictor and walk
// counters to zero, the sequencer to its idle step.
module jpeg_dc_mcu_scatter_top #(
  parameter int MAX_DUS_SIDE = dcs_pkg::MAX_DUS_SIDE_DEF,
  parameter int MAX_SAMPLING = dcs_pkg::MAX_SAMPLING_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
  dcs_in_if.sink                         dc_in,
  dcs_out_if.source                      pix_out
);
  import dcs_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    in_accept;

  assign dc_in.ready = ctrl.in_ready;
  assign in_accept   = dc_in.valid && ctrl.in_ready;

  dcs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dc_in.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  dcs_datapath #(
    .MAX_DUS_SIDE (MAX_DUS_SIDE),
    .MAX_SAMPLING (MAX_SAMPLING)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctrl        (ctrl),
    .status      (status),
    .in_accept   (in_accept),
    .dc_diff     (dc_in.dc_diff),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .entry_index (pix_out.entry_index),
    .pixel_value (pix_out.pixel_value),
    .last_write  (pix_out.last_write),
    .grid_full   (pix_out.grid_full),
    .overflow    (pix_out.overflow)
  );

endmodule
